[rtl/crcps_pkg.sv]
// ----------------------------------------------------------------------------
// crcps_pkg
// Shared types, register codes and the CRC byte-step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package crcps_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] SEED_RESET = 32'h0000_0000;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY    = 2'd0,
    CFG_SEED    = 2'd1,
    CFG_REFLECT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    crc_t poly;
    crc_t seed;
    logic reflect;
  } crcps_cfg_t;

  // bit reversal of one byte
  function automatic byte_t flip_byte(input byte_t b);
    byte_t r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

  // msb-first absorb of one byte, eight shift/xor steps
  function automatic crc_t absorb_byte(input crc_t acc, input byte_t b, input crc_t poly);
    crc_t a;
    a = acc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (a[CRC_W-1]) begin
        a = {a[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        a = {a[CRC_W-2:0], 1'b0};
      end
    end
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/crcps_if.sv]
// ----------------------------------------------------------------------------
// crcps_if
// Valid/ready channels for message bytes and finished CRC words.
// ----------------------------------------------------------------------------
`default_nettype none

interface crcps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface crcps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_result;

  modport source (output valid, output crc_result, input ready);
  modport sink   (input valid, input crc_result, output ready);
endinterface

`default_nettype wire

[rtl/crcps_cfg.sv]
// ----------------------------------------------------------------------------
// crcps_cfg
// Configuration register bank: polynomial, seed and reflect mode.
// ----------------------------------------------------------------------------
`default_nettype none

module crcps_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [crcps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crcps_pkg::CRC_W-1:0]     cfg_data,
  output crcps_pkg::crcps_cfg_t                cfg
);
  import crcps_pkg::*;

  crcps_cfg_t cfg_r;
  crcps_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLY:    cfg_nxt.poly    = cfg_data;
        CFG_SEED:    cfg_nxt.seed    = cfg_data;
        CFG_REFLECT: cfg_nxt.reflect = cfg_data[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly    <= POLY_RESET;
      cfg_r.seed    <= SEED_RESET;
      cfg_r.reflect <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/crcps_core.sv]
// ----------------------------------------------------------------------------
// crcps_core
// Input byte register, combinational CRC byte step and the running CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module crcps_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  crcps_pkg::crcps_cfg_t            cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [crcps_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                        in_first,
  input  wire logic                        in_last,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic [crcps_pkg::CRC_W-1:0]      res_crc
);
  import crcps_pkg::*;

  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_first_r;
  logic  s1_last_r;
  crc_t  running_crc_r;
  crc_t  running_crc_nxt;
  logic  s1_go;
  byte_t step_byte;
  crc_t  step_start;

  // a byte that closes a message waits until the result register has room
  assign s1_go    = s1_valid_r && (!s1_last_r || res_ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign step_byte       = cfg.reflect ? flip_byte(s1_byte_r) : s1_byte_r;
  assign step_start      = s1_first_r ? cfg.seed : running_crc_r;
  assign running_crc_nxt = absorb_byte(step_start, step_byte, cfg.poly);

  assign res_valid = s1_valid_r && s1_last_r;
  assign res_crc   = running_crc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      running_crc_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        running_crc_r <= running_crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_byte;
      s1_first_r <= in_first;
      s1_last_r  <= in_last;
    end
  end

  a_go_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> s1_valid_r)
    else $error("byte step taken without a byte in the input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(running_crc_r)))
    else $error("stalled byte or running crc changed");

  a_idle_crc_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> $stable(running_crc_r))
    else $error("running crc moved without a byte step");

endmodule

`default_nettype wire

[rtl/crcps_out.sv]
// ----------------------------------------------------------------------------
// crcps_out
// Result register between the byte step and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crcps_out (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       res_valid,
  output logic                            res_ready,
  input  wire logic [crcps_pkg::CRC_W-1:0] res_crc,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [crcps_pkg::CRC_W-1:0]     out_crc
);
  import crcps_pkg::*;

  logic out_valid_r;
  crc_t out_crc_r;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_crc_r <= res_crc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_crc   = out_crc_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (out_valid_r && out_crc_r == $past(res_crc)))
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !res_ready)
    else $error("pending result could be overwritten");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !res_valid) |=> !out_valid_r)
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire

[rtl/crc32_programmable_stream_top.sv]
// ----------------------------------------------------------------------------
// crc32_programmable_stream_top
// Streaming msb-first crc-32 over bytes with programmable polynomial and seed.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle for as long as results are
// drained. Each accepted byte is held in an input register, where the full
// eight-step shift/xor network (optional byte reversal first) updates the
// running crc; a byte flagged last also loads the result register, which
// presents it on the result channel. The single combinational byte step sets
// the throughput. The result register lets new bytes enter while a result
// waits; only a second last byte stalls until the first result is taken.
// Configuration registers (polynomial, seed, reflect) are written through
// cfg_we/cfg_index/cfg_data and should change only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_programmable_stream_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  crcps_in_if.sink                             in_ch,
  crcps_out_if.source                          out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [crcps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crcps_pkg::CRC_W-1:0]     cfg_data
);
  import crcps_pkg::*;

  crcps_cfg_t cfg;
  logic       res_valid;
  logic       res_ready;
  crc_t       res_crc;

  crcps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crcps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.data_byte),
    .in_first  (in_ch.first_byte),
    .in_last   (in_ch.last_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_crc   (res_crc)
  );

  crcps_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_crc   (res_crc),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_crc   (out_ch.crc_result)
  );

endmodule

`default_nettype wire

[verif/tb_crc32_programmable_stream_top.sv]
// ----------------------------------------------------------------------------
// tb_crc32_programmable_stream_top
// Self-checking bench for the streaming msb-first crc-32 block. Byte words go
// in over a valid/ready channel with random gaps. Finished crc words come back
// under random and long output stalls. A scoreboard folds every accepted byte
// into its own crc and compares each crc word in order. Polynomial, seed and
// reflect settings change between drained phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_crc32_programmable_stream_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crcps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam int unsigned          CYCLE_LIMIT = 200000;
  localparam int unsigned          TAIL_CYCLES = 8;

  class crc_tracker;
    crcps_cfg_t  regs;
    crc_t        running;
    crc_t        pending_crcs[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned crcs_checked;

    function new();
      regs.poly    = POLY_RESET;
      regs.seed    = SEED_RESET;
      regs.reflect = 1'b0;
      running      = '0;
      errors       = 0;
      bytes_seen   = 0;
      crcs_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, crc_t value);
      case (idx)
        CFG_POLY:    regs.poly    = value;
        CFG_SEED:    regs.seed    = value;
        CFG_REFLECT: regs.reflect = value[0];
        default:     ;
      endcase
    endfunction

    function crc_t fold_byte(crc_t acc, byte_t b);
      crc_t  r;
      byte_t d;
      d = b;
      if (regs.reflect) begin
        d = {<<{b}};
      end
      r = acc ^ (crc_t'(d) << 24);
      // mask picks the polynomial when the old top bit was set
      repeat (BYTE_W) r = (r << 1) ^ (regs.poly & {CRC_W{r[CRC_W-1]}});
      return r;
    endfunction

    function void note_byte(byte_t b, logic is_first, logic is_last);
      running = fold_byte(is_first ? regs.seed : running, b);
      bytes_seen++;
      if (is_last) begin
        pending_crcs.push_back(running);
      end
    endfunction

    function void check_crc(crc_t actual);
      crc_t want;
      if (pending_crcs.size() == 0) begin
        errors++;
        $display("%0t: unexpected crc word: expected none, actual %08h", $time, actual);
      end else begin
        want = pending_crcs.pop_front();
        crcs_checked++;
        if (want !== actual) begin
          errors++;
          $display("%0t: crc_result mismatch: expected %08h, actual %08h",
                   $time, want, actual);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  crc_t                 cfg_data;

  crcps_in_if  in_ch();
  crcps_out_if out_ch();

  crc_tracker  sb;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold_cycles;
  int unsigned cycle_count;

  crc32_programmable_stream_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("crc32_programmable_stream_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_byte(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_crc(out_ch.crc_result);
    end
  end

  // output side: random stalls, plus a long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(99) < 26);
      end
    end
  end

  function automatic byte_t pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    if (roll < 25) return 8'h80;
    if (roll < 30) return 8'h01;
    return byte_t'($urandom);
  endfunction

  // called and returns at a falling edge
  task automatic send_byte(byte_t b, logic is_first, logic is_last);
    while (tx_idle_on && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= is_first;
    in_ch.last_byte  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending_crcs.size() != 0) @(posedge clk);
    // a trailing non-last byte may still be in flight
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drive_reg(logic [CFG_IDX_W-1:0] idx, crc_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic set_config(crc_t poly, crc_t seed, logic refl, bit touch_spare);
    drive_reg(CFG_POLY, poly);
    drive_reg(CFG_SEED, seed);
    drive_reg(CFG_REFLECT, {$urandom} & ~crc_t'(1) | crc_t'(refl));
    if (touch_spare) begin
      drive_reg(CFG_SPARE, $urandom);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly framed messages, some stray bytes with random flags
  task automatic send_random(int unsigned count);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 7) : $urandom_range(6, 1);
        for (int unsigned i = 0; i < len; i++) begin
          send_byte(pick_byte(), i == 0, i == len - 1);
        end
        sent += len;
      end else begin
        send_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    crc_t poly;
    crc_t seed;
    logic refl;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    rx_hold_cycles   = 0;
    cycle_count      = 0;
    sb               = new();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // continuation straight out of reset starts from zero
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    // single-byte messages at the byte extremes
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    // message, then a continuation from its final crc
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1);
    send_byte(8'h56, 1'b0, 1'b1);
    // restart in the middle of an open message
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b1, 1'b0);
    send_byte(8'h44, 1'b0, 1'b1);

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: begin poly = POLY_RESET;   seed = '1;       refl = 1'b1; end
        2: begin poly = '0;           seed = '0;       refl = 1'b0; end
        3: begin poly = '1;           seed = '1;       refl = 1'b0; end
        4: begin poly = $urandom;     seed = $urandom; refl = 1'b1; end
        5: begin poly = 32'h1EDC6F41; seed = $urandom; refl = 1'($urandom_range(1)); end
        default: begin
          poly = $urandom; seed = '0; refl = 1'($urandom_range(1));
        end
      endcase
      drain_results();
      set_config(poly, seed, refl, ph == 4);
      if (ph == 2) begin
        rx_hold_cycles = 300;
      end
      if (ph == 3) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_random(150);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      if (ph == 5) begin
        drain_results();
      end
      send_random(150);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_crcs.size() != 0) begin
      $display("%0t: %0d crc words never arrived, first expected %08h",
               $time, sb.pending_crcs.size(), sb.pending_crcs[0]);
      sb.errors += sb.pending_crcs.size();
    end

    $display("covered %0d byte words and %0d crc words over seven register settings,",
             sb.bytes_seen, sb.crcs_checked);
    $display("with a long output hold, drained pauses and an unmapped register write");
    if (sb.errors == 0) begin
      $display("crc32_programmable_stream_top regression: pass");
    end else begin
      $display("crc32_programmable_stream_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
